// ----- design/count_min_sketch_with_aging_macros.svh -----
// Assertion macros for the count-min sketch block.
// Depends on nothing; included by the top level only.
`ifndef COUNT_MIN_SKETCH_WITH_AGING_MACROS_SVH
`define COUNT_MIN_SKETCH_WITH_AGING_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define CMS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication.
`define CMS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// ----- design/cms_pkg.sv -----
// Shared types, constants and hash helpers of the count-min sketch.
// Depends on nothing.
`default_nettype none
package cms_pkg;
	localparam int ROWS = 4;
	localparam int COLUMNS = 512;
	localparam int COL_W = $clog2(COLUMNS);
	localparam int NUM_REGS = 8;
	localparam int REG_W = 31;
	localparam int TOTAL_W = 17;
	localparam logic [TOTAL_W-1:0] AGING_LIMIT = 17'd100000;
	// 2^32 + 15
	localparam logic [32:0] HASH_PRIME = 33'h1_0000_000F;

	typedef enum logic [1:0] {
		OP_ESTIMATE = 2'd0,
		OP_UPDATE   = 2'd1,
		OP_INCR     = 2'd2,
		OP_UNUSED   = 2'd3
	} op_t;

	typedef struct packed {
		op_t             op;
		logic [7:0]      count;
		logic [15:0]     rnd;
		logic [ROWS-1:0][COL_W-1:0] cols;
	} job_t;

	typedef struct packed {
		logic [7:0] estimate;
		logic       updated;
		logic       cleared;
	} res_t;
endpackage
`default_nettype wire

// ----- design/cms_front.sv -----
// Front end: accepts items and hashes the key into one column per row.
// Depends on cms_pkg. Four-stage pipeline, one item at a time.
`default_nettype none
module cms_front import cms_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  wire logic [1:0]  op,
	input  wire logic [30:0] key,
	input  wire logic [7:0]  count,
	input  wire logic [15:0] rnd,
	input  wire logic [NUM_REGS-1:0][REG_W-1:0] regs,
	output logic      job_valid,
	input  wire logic job_ready,
	output job_t      job
);
	// Stage 1: low and high 31x16 partial products per row.
	// Stage 2: product + offset (63 bits). Stage 3/4: mod prime by 2^32 = -15.
	logic [2:0] busy_q;
	logic [1:0] op_s1;
	logic [7:0] cnt_s1;
	logic [15:0] rnd_s1;
	logic [ROWS-1:0][46:0] pl_s1, ph_s1;
	logic [ROWS-1:0][30:0] b_s1;
	logic [ROWS-1:0][62:0] h_s2;
	logic [ROWS-1:0][36:0] f_s3;
	logic out_q;

	assign in_ready = (busy_q == 3'b000) && !out_q;
	assign job_valid = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= '0;
			out_q <= 1'b0;
		end else begin
			busy_q <= {busy_q[1:0], in_valid && in_ready};
			if (busy_q[2]) out_q <= 1'b1;
			else if (job_ready) out_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_s1 <= op;
			cnt_s1 <= count;
			rnd_s1 <= rnd;
		end
		for (int r = 0; r < ROWS; r++) begin
			if (in_valid && in_ready) begin
				pl_s1[r] <= 47'(regs[2*r] * key[15:0]);
				ph_s1[r] <= 47'(regs[2*r] * key[30:16]);
				b_s1[r] <= regs[2*r+1];
			end
			h_s2[r] <= 63'({ph_s1[r], 16'b0}) + 63'(pl_s1[r]) + 63'(b_s1[r]);
			// fold high part: hi*2^32 = -15*hi mod p, so x = lo - 15*hi + 15*p margin
			f_s3[r] <= 37'(h_s2[r][31:0]) + 37'(HASH_PRIME) * 37'd15
				- 37'(h_s2[r][62:32]) * 37'd15;
		end
		if (busy_q[2]) begin
			job.op <= op_t'(op_s1);
			job.count <= cnt_s1;
			job.rnd <= rnd_s1;
			for (int r = 0; r < ROWS; r++) begin
				job.cols[r] <= col_of(f_s3[r]);
			end
		end
	end

	// f < 16p; reduce with a second fold then two compare-and-subtract steps.
	function automatic logic [COL_W-1:0] col_of(input logic [36:0] f);
		logic [33:0] g;
		logic [33:0] m;
		g = 34'(f[31:0]) + 34'(HASH_PRIME) - 34'(f[36:32]) * 34'd15;
		m = (g >= 34'(HASH_PRIME)) ? g - 34'(HASH_PRIME) : g;
		m = (m >= 34'(HASH_PRIME)) ? m - 34'(HASH_PRIME) : m;
		return m[COL_W-1:0];
	endfunction
endmodule
`default_nettype wire

// ----- design/cms_back.sv -----
// Back end: counter memories, estimate, update, aging clear and result register.
// Depends on cms_pkg.
`default_nettype none
module cms_back import cms_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic job_valid,
	output logic      job_ready,
	input  job_t      job,
	output logic      res_valid,
	input  wire logic res_ready,
	output res_t      res
);
	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_READ  = 4'b0010,
		ST_DO    = 4'b0100,
		ST_CLEAR = 4'b1000
	} st_t;
	st_t st_q;
	logic [7:0] mem0 [COLUMNS], mem1 [COLUMNS], mem2 [COLUMNS], mem3 [COLUMNS];
	logic [ROWS-1:0][7:0] rd_q;
	job_t job_q;
	logic [TOTAL_W-1:0] total_q;
	logic [COL_W-1:0] clr_q;
	logic pend_q;
	logic [7:0] est;
	logic do_up, clr_now;
	logic [TOTAL_W:0] sum;
	logic [27:0] prod;
	logic we;
	logic [COL_W-1:0] wa [ROWS];
	logic [7:0] wd [ROWS];

	always_comb begin
		est = rd_q[0];
		for (int r = 1; r < ROWS; r++) if (rd_q[r] < est) est = rd_q[r];
		prod = 28'(job_q.rnd) * 28'(10 * {2'b0, est} + 10'd1);
		unique case (job_q.op)
			OP_UPDATE: do_up = 1'b1;
			OP_INCR:   do_up = prod < 28'd65536;
			default:   do_up = 1'b0;
		endcase
		sum = {1'b0, total_q} + (TOTAL_W+1)'(job_q.count);
		clr_now = sum >= (TOTAL_W+1)'(AGING_LIMIT);
		we = 1'b0;
		for (int r = 0; r < ROWS; r++) begin
			wa[r] = job_q.cols[r];
			wd[r] = rd_q[r] + job_q.count;
		end
		if (st_q == ST_CLEAR) begin
			we = 1'b1;
			// The reset pass writes zeros only; an aging pass lays the count in.
			for (int r = 0; r < ROWS; r++) begin
				wa[r] = clr_q;
				wd[r] = (pend_q && (clr_q == job_q.cols[r])) ? job_q.count : 8'd0;
			end
		end else if (st_q == ST_DO && do_up && !clr_now && !res_valid) we = 1'b1;
	end

	assign job_ready = (st_q == ST_IDLE);

	always_ff @(posedge clk) begin
		if (we) begin
			mem0[wa[0]] <= wd[0]; mem1[wa[1]] <= wd[1];
			mem2[wa[2]] <= wd[2]; mem3[wa[3]] <= wd[3];
		end
		if (st_q == ST_READ) begin
			rd_q[0] <= mem0[job_q.cols[0]]; rd_q[1] <= mem1[job_q.cols[1]];
			rd_q[2] <= mem2[job_q.cols[2]]; rd_q[3] <= mem3[job_q.cols[3]];
		end
		if (job_valid && job_ready) job_q <= job;
		if (st_q == ST_DO && !res_valid) begin
			res.estimate <= est;
			res.updated <= do_up;
			res.cleared <= do_up && clr_now;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_CLEAR;
			pend_q <= 1'b0;
			clr_q <= '0;
			total_q <= '0;
			res_valid <= 1'b0;
		end else begin
			if (res_valid && res_ready) res_valid <= 1'b0;
			unique case (st_q)
				ST_IDLE: if (job_valid) st_q <= ST_READ;
				ST_READ: st_q <= ST_DO;
				ST_DO: if (!res_valid) begin
					res_valid <= 1'b1;
					if (do_up && clr_now) begin
						total_q <= '0;
						pend_q <= 1'b1;
						clr_q <= '0;
						st_q <= ST_CLEAR;
					end else begin
						if (do_up) total_q <= sum[TOTAL_W-1:0];
						st_q <= ST_IDLE;
					end
				end
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == COL_W'(COLUMNS-1)) begin
						st_q <= ST_IDLE;
						pend_q <= 1'b0;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ----- design/count_min_sketch_with_aging.sv -----
// Top level of the count-min sketch with aging: config registers, front, back.
// Depends on cms_pkg, cms_front, cms_back and the macros header.
//
// channel | dir | handshake              | payload
// s_axis  | in  | s_axis_tvalid/tready   | tdata: key, count, rnd; tuser: operation
// m_axis  | out | m_axis_tvalid/tready   | tdata: estimate; tuser: updated, cleared
// cfg     | in  | cfg_valid/cfg_ready    | cfg_index, cfg_data
//
// A result is registered after its input transaction passes the hash pipeline up to
// the job register and then the back end (job capture, counter read, then update).
// The front takes a new input only once the previous item has passed to the back end.
// Reset starts a clearing pass over all 512 columns; an aging clear starts another.
// Either side may stall; results wait in the output register.
`default_nettype none
`include "count_min_sketch_with_aging_macros.svh"
module count_min_sketch_with_aging import cms_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_axis_tvalid,
	output logic      s_axis_tready,
	input  wire logic [55:0] s_axis_tdata, // key[30:0], count[38:31], random_fraction[54:39]
	input  wire logic [1:0]  s_axis_tuser, // operation
	output logic      m_axis_tvalid,
	input  wire logic m_axis_tready,
	output logic [7:0] m_axis_tdata,       // estimate
	output logic [1:0] m_axis_tuser,       // updated[0], table_cleared[1]
	input  wire logic cfg_valid,
	output logic      cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [30:0] cfg_data
);
	logic [NUM_REGS-1:0][REG_W-1:0] regs_q;
	logic jv, jr;
	job_t jb;
	res_t rs;

	assign cfg_ready = 1'b1;
	// Hold hash registers; all reset to one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) regs_q[i] <= REG_W'(1);
		end else if (cfg_valid) begin
			regs_q[cfg_index] <= cfg_data;
		end
	end

	cms_front u_front (
		.clk, .arst_n,
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.op(s_axis_tuser), .key(s_axis_tdata[30:0]), .count(s_axis_tdata[38:31]),
		.rnd(s_axis_tdata[54:39]), .regs(regs_q),
		.job_valid(jv), .job_ready(jr), .job(jb)
	);

	cms_back u_back (
		.clk, .arst_n,
		.job_valid(jv), .job_ready(jr), .job(jb),
		.res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res(rs)
	);

	assign m_axis_tdata = rs.estimate;
	assign m_axis_tuser = {rs.cleared, rs.updated};

	`CMS_ASSERT_IMP(a_clear_implies_update, clk, arst_n, m_axis_tvalid && m_axis_tuser[1], m_axis_tuser[0], "clear without update")
	`CMS_ASSERT_NEXT(a_res_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result dropped")
endmodule
`default_nettype wire

// ----- tb/count_min_sketch_with_aging_test.sv -----
// Self-checking testbench of the count-min sketch with aging: directed items, then random phases.
// Depends on cms_pkg and the count_min_sketch_with_aging top level.
`timescale 1ns / 1ps
`default_nettype none
module count_min_sketch_with_aging_test;
	import cms_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int POOL = 16;

	// Sketch model: its own copy of the hash coefficients, the counters and the
	// running total, and the queue of results still to come out of the block.
	class sketch_scoreboard;
		bit [30:0] coeff [NUM_REGS];
		bit [7:0]  counters [ROWS][COLUMNS];
		bit [16:0] total;
		res_t      awaited [$];
		int        errors;
		int        checked;
		int        clears;

		function new();
			foreach (coeff[i])
				coeff[i] = 31'd1;
			foreach (counters[r, c])
				counters[r][c] = 8'd0;
			total = '0;
		endfunction

		function void write_coeff(int idx, bit [30:0] value);
			coeff[idx] = value;
		endfunction

		function bit [8:0] column(int r, bit [30:0] key);
			bit [63:0] h;
			h = {33'b0, coeff[2*r]} * {33'b0, key} + {33'b0, coeff[2*r+1]};
			h = h % {31'b0, HASH_PRIME};
			return h[8:0];
		endfunction

		// Note an accepted input transaction and work out the result it causes.
		function void note_item(op_t op, bit [30:0] key, bit [7:0] count, bit [15:0] rnd);
			bit [8:0]  cols [ROWS];
			bit [7:0]  least;
			bit [31:0] sum;
			res_t      res;
			least = 8'hFF;
			for (int r = 0; r < ROWS; r++) begin
				cols[r] = column(r, key);
				if (counters[r][cols[r]] < least)
					least = counters[r][cols[r]];
			end
			res.estimate = least;
			res.cleared = 1'b0;
			case (op)
				OP_UPDATE: res.updated = 1'b1;
				OP_INCR:   res.updated = (32'(rnd) * (32'd10 * least + 32'd1)) < 32'd65536;
				default:   res.updated = 1'b0;
			endcase
			if (res.updated) begin
				sum = 32'(total) + 32'(count);
				if (sum >= 32'(AGING_LIMIT)) begin
					foreach (counters[r, c])
						counters[r][c] = 8'd0;
					sum = 0;
					res.cleared = 1'b1;
					clears++;
				end
				total = sum[16:0];
				for (int r = 0; r < ROWS; r++)
					counters[r][cols[r]] += count;
			end
			awaited.push_back(res);
		endfunction

		// Compare one output transaction with the oldest pending result.
		function void check_result(bit [7:0] estimate, bit updated, bit cleared);
			res_t exp_res;
			if (awaited.size() == 0) begin
				$display("%0t: unexpected result est=%0d upd=%0b clr=%0b", $time,
					estimate, updated, cleared);
				errors++;
				return;
			end
			exp_res = awaited.pop_front();
			checked++;
			if (exp_res.estimate !== estimate) begin
				$display("%0t: estimate expected %0d actual %0d", $time,
					exp_res.estimate, estimate);
				errors++;
			end
			if (exp_res.updated !== updated) begin
				$display("%0t: updated expected %0b actual %0b", $time,
					exp_res.updated, updated);
				errors++;
			end
			if (exp_res.cleared !== cleared) begin
				$display("%0t: table_cleared expected %0b actual %0b", $time,
					exp_res.cleared, cleared);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [55:0] s_axis_tdata;
	logic [1:0]  s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [7:0]  m_axis_tdata;
	logic [1:0]  m_axis_tuser;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [30:0] cfg_data;

	sketch_scoreboard sb;
	event      item_taken;
	event      cfg_taken;
	bit        quiet;
	int        sink_stall;
	int        cycles;
	bit [30:0] key_pool [POOL];

	count_min_sketch_with_aging DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Abandon the run if the block hangs.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles", $time, cycles);
			$display("** count_min_sketch_with_aging: FAILED **");
			$finish;
		end
	end

	// Record each transaction at the edge where it is accepted; inputs settled at the
	// previous falling edge, so the values read here are the ones the block takes.
	always @(posedge clk) begin
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			sb.note_item(op_t'(s_axis_tuser), s_axis_tdata[30:0], s_axis_tdata[38:31],
				s_axis_tdata[54:39]);
			-> item_taken;
		end
		if (arst_n && cfg_valid && cfg_ready) begin
			sb.write_coeff(int'(cfg_index), cfg_data);
			-> cfg_taken;
		end
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata, m_axis_tuser[0], m_axis_tuser[1]);
	end

	// Result side back-pressure: random bursts of stall, none once quiet is set.
	always @(negedge clk) begin
		if (quiet) begin
			m_axis_tready <= 1'b1;
		end else if (sink_stall > 0) begin
			m_axis_tready <= 1'b0;
			sink_stall--;
		end else if ($urandom_range(0, 5) == 0) begin
			m_axis_tready <= 1'b0;
			sink_stall = $urandom_range(0, 12);
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// Hold one item on the input until the block takes it, then drop valid.
	task automatic send_item(op_t op, bit [30:0] key, bit [7:0] count, bit [15:0] rnd);
		int gap;
		if (!quiet && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 13);
			repeat (gap) @(negedge clk);
		end
		@(negedge clk);
		s_axis_tdata = {1'b0, rnd, count, key};
		s_axis_tuser = op;
		s_axis_tvalid = 1'b1;
		@(item_taken);
		@(negedge clk);
		s_axis_tvalid = 1'b0;
	endtask

	task automatic write_coeff(bit [2:0] idx, bit [30:0] value);
		@(negedge clk);
		cfg_index = idx;
		cfg_data = value;
		cfg_valid = 1'b1;
		@(cfg_taken);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Wait for every pending result, then let the back end settle.
	task automatic drain();
		while (sb.awaited.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic random_item(bit heavy);
		int        pick;
		op_t       op;
		bit [30:0] key;
		bit [7:0]  count;
		bit [15:0] rnd;
		pick = $urandom_range(0, 99);
		if (heavy)
			op = OP_UPDATE;
		else if (pick < 60)
			op = OP_UPDATE;
		else if (pick < 85)
			op = OP_INCR;
		else if (pick < 95)
			op = OP_ESTIMATE;
		else
			op = OP_UNUSED;
		// Mostly reuse a small set of keys so the counters build up.
		key = ($urandom_range(0, 9) < 7) ? key_pool[$urandom_range(0, POOL-1)]
			: 31'($urandom());
		if (heavy)
			count = 8'($urandom_range(250, 255));
		else
			count = ($urandom_range(0, 4) < 4) ? 8'($urandom_range(200, 255))
				: 8'($urandom());
		rnd = $urandom_range(0, 1) ? 16'($urandom_range(0, 2000)) : 16'($urandom());
		send_item(op, key, count, rnd);
	endtask

	initial begin
		sb = new();
		quiet = 1'b0;
		sink_stall = 0;
		cycles = 0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = OP_ESTIMATE;
		m_axis_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		foreach (key_pool[i])
			key_pool[i] = 31'($urandom());
		key_pool[0] = 31'd0;
		key_pool[1] = 31'h7FFF_FFFF;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part under reset coefficients.
		send_item(OP_ESTIMATE, 31'd0, 8'd0, 16'd0);
		send_item(OP_ESTIMATE, 31'h7FFF_FFFF, 8'hFF, 16'hFFFF);
		send_item(OP_UPDATE, 31'd5, 8'hFF, 16'd0);
		send_item(OP_UPDATE, 31'd5, 8'd3, 16'd0);          // counter wraps
		send_item(OP_ESTIMATE, 31'd5, 8'd0, 16'd0);
		send_item(OP_UPDATE, 31'd9, 8'd0, 16'd0);          // zero count still updates
		send_item(OP_INCR, 31'd77, 8'd1, 16'hFFFF);        // empty cell, always accepted
		send_item(OP_INCR, 31'd77, 8'd1, 16'd5957);        // est 1: 5957*11 < 65536
		send_item(OP_INCR, 31'd77, 8'd1, 16'd3121);        // est 2: 3121*21 = 65541, rejected
		send_item(OP_INCR, 31'd77, 8'd1, 16'd0);
		send_item(OP_UNUSED, 31'd77, 8'hFF, 16'd0);        // unused code acts as estimate
		send_item(OP_UPDATE, 31'h7FFF_FFFF, 8'hFF, 16'hFFFF);
		send_item(OP_INCR, 31'h7FFF_FFFF, 8'd8, 16'hFFFF); // rejected on a full-ish cell
		drain();

		// Phases of random items, each under its own coefficients.
		for (int phase = 0; phase < 5; phase++) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				case (phase)
					0: write_coeff(3'(i), 31'h7FFF_FFFF);
					1: write_coeff(3'(i), 31'($urandom()));
					2: write_coeff(3'(i), 31'd0);        // every key lands on one column
					3: write_coeff(3'(i), (i % 2) ? 31'd1 : 31'($urandom()));
					default: write_coeff(3'(i), 31'($urandom()));
				endcase
			end
			if (phase == 4)
				quiet = 1'b1;
			// The first phase is update-heavy so the aging limit is passed.
			for (int n = 0; n < ((phase == 0) ? 420 : 30); n++) begin
				random_item(phase == 0);
				if (phase == 1 && n == 15)
					drain();
			end
			drain();
		end

		drain();
		$display("Checked %0d results over five coefficient settings; %0d aging clears seen.",
			sb.checked, sb.clears);
		if (sb.errors == 0 && sb.awaited.size() == 0) begin
			$display("** count_min_sketch_with_aging: PASSED **");
		end else begin
			$display("** count_min_sketch_with_aging: FAILED **");
		end
		$finish;
	end
endmodule
`default_nettype wire
